// File: rtl/core/rlcg_pkg.sv
// ----------------------------------------------------------------------------
// rlcg_pkg
// Shared types and constants of the ranged LCG random draw: generator
// constants, divider width, sequencer states and the control structs that
// pass between the modules.
// ----------------------------------------------------------------------------
package rlcg_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned DIV_W   = 31;
   localparam int unsigned COUNT_W = $clog2(DIV_W);

   localparam logic [WORD_W-1:0] LCG_MUL    = 32'd1664525;
   localparam logic [WORD_W-1:0] LCG_ADD    = 32'd1013904223;
   localparam logic [DIV_W-1:0]  RAW_OFFSET = 31'h4000_0000;
   localparam logic [DIV_W-1:0]  RAW_MAX    = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEED,
      ST_STEP,
      ST_DIV_SPAN,
      ST_DIV_RAW,
      ST_CLAMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef struct packed {
      logic load_tick;
      logic step;
   } lcg_ctrl_type;

endpackage

// File: rtl/core/rlcg_divider.sv
// ----------------------------------------------------------------------------
// rlcg_divider
// Shared radix-2 restoring divider, one quotient bit per cycle. Unsigned
// operands of rlcg_pkg::DIV_W bits; the divisor must be non-zero. Done pulses
// for one cycle with the quotient held until the next start.
// ----------------------------------------------------------------------------
module rlcg_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  rlcg_pkg::div_ctrl_type      ctrl,
   input  logic [rlcg_pkg::DIV_W-1:0]  dividend,
   input  logic [rlcg_pkg::DIV_W-1:0]  divisor,
   output logic [rlcg_pkg::DIV_W-1:0]  quotient,
   output rlcg_pkg::div_status_type    status
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [rlcg_pkg::COUNT_W-1:0]  count_ff;
   logic [rlcg_pkg::DIV_W-1:0]    quot_ff;
   logic [rlcg_pkg::DIV_W-1:0]    rem_ff;
   logic [rlcg_pkg::DIV_W-1:0]    divisor_ff;

   logic [rlcg_pkg::DIV_W:0]      shifted;
   logic [rlcg_pkg::DIV_W+1:0]    trial;
   logic                          last;

   assign shifted = {rem_ff, quot_ff[rlcg_pkg::DIV_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor_ff};
   assign last    = (count_ff == rlcg_pkg::COUNT_W'(rlcg_pkg::DIV_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (ctrl.start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         quot_ff    <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         if (!trial[rlcg_pkg::DIV_W+1]) begin
            rem_ff  <= trial[rlcg_pkg::DIV_W-1:0];
            quot_ff <= {quot_ff[rlcg_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_ff  <= shifted[rlcg_pkg::DIV_W-1:0];
            quot_ff <= {quot_ff[rlcg_pkg::DIV_W-2:0], 1'b0};
         end
      end
   end

   assign quotient    = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: rtl/core/rlcg_lcg.sv
// ----------------------------------------------------------------------------
// rlcg_lcg
// Seed register and one-step linear congruential update,
// seed := 1664525 * x + 1013904223 mod 2^32, with x the tick or the seed.
// ----------------------------------------------------------------------------
module rlcg_lcg (
   input  logic                         clock,
   input  logic                         reset,
   input  rlcg_pkg::lcg_ctrl_type       ctrl,
   input  logic [rlcg_pkg::WORD_W-1:0]  tick,
   output logic [rlcg_pkg::WORD_W-1:0]  seed
);

   logic [rlcg_pkg::WORD_W-1:0] seed_ff;
   logic [rlcg_pkg::WORD_W-1:0] operand;
   logic [rlcg_pkg::WORD_W-1:0] product;

   assign operand = ctrl.load_tick ? tick : seed_ff;
   assign product = rlcg_pkg::WORD_W'(operand * rlcg_pkg::LCG_MUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (ctrl.load_tick || ctrl.step) begin
         seed_ff <= product + rlcg_pkg::LCG_ADD;
      end
   end

   assign seed = seed_ff;

endmodule

// File: rtl/core/ranged_lcg_random.sv
// ----------------------------------------------------------------------------
// ranged_lcg_random
// Ranged random draw from a 32-bit linear congruential generator, scaled
// into a signed range by two divisions on a shared radix-2 divider.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata (low bit up)                         tuser
//  req_      in         range_low, range_high, tick_entropy (96b)  -
//  rsp_      out        random_value (32b)                         span_error
//
//  A draw runs two 31-step passes of the divider, after reseeding from
//  the tick when the seed is zero. A single-value or inverted range
//  returns range_low, an oversized one also span_error, with no division.
//  Reset clears the seed to zero (unseeded) and empties the result register.
//  req_tready is high only when idle; a stalled result holds the sequencer.
//
module ranged_lcg_random (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // range_low, range_high, tick_entropy
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // random_value
   output logic         rsp_tuser    // span_error
);

   rlcg_pkg::state_type state_ff, state_in;

   logic signed [31:0]         lo_ff;
   logic signed [31:0]         hi_ff;
   logic [31:0]                tick_ff;
   logic [rlcg_pkg::DIV_W-1:0] span_ff;
   logic signed [32:0]         value_ff;
   logic [31:0]                result_ff;
   logic                       err_ff;
   logic                       rsp_valid_ff;
   logic [31:0]                rsp_data_ff;
   logic                       rsp_user_ff;

   rlcg_pkg::div_ctrl_type     div_ctrl;
   rlcg_pkg::div_status_type   div_status;
   rlcg_pkg::lcg_ctrl_type     lcg_ctrl;
   logic [rlcg_pkg::DIV_W-1:0] div_dividend;
   logic [rlcg_pkg::DIV_W-1:0] div_divisor;
   logic [rlcg_pkg::DIV_W-1:0] div_quotient;
   logic [31:0]                seed;
   logic [rlcg_pkg::DIV_W-1:0] raw;

   logic signed [32:0]         diff;
   logic                       in_order;
   logic                       too_wide;
   logic                       req_xfer;
   logic                       out_free;

   assign req_xfer = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign diff     = {hi_ff[31], hi_ff} - {lo_ff[31], lo_ff};
   assign in_order = !diff[32] && (diff != 33'sd0);
   assign too_wide = diff >= 33'sh0_7FFF_FFFF;
   assign raw      = seed[31:1] ^ rlcg_pkg::RAW_OFFSET;

   rlcg_lcg u_lcg (
      .clock (clock),
      .reset (reset),
      .ctrl  (lcg_ctrl),
      .tick  (tick_ff),
      .seed  (seed)
   );

   rlcg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rlcg_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = rlcg_pkg::ST_CHECK;
            end
         end
         rlcg_pkg::ST_CHECK: begin
            if (!in_order || too_wide) begin
               state_in = rlcg_pkg::ST_DONE;
            end else if (seed == '0) begin
               state_in = rlcg_pkg::ST_SEED;
            end else begin
               state_in = rlcg_pkg::ST_STEP;
            end
         end
         rlcg_pkg::ST_SEED:     state_in = rlcg_pkg::ST_STEP;
         rlcg_pkg::ST_STEP:     state_in = rlcg_pkg::ST_DIV_SPAN;
         rlcg_pkg::ST_DIV_SPAN: begin
            if (div_status.done) begin
               state_in = rlcg_pkg::ST_DIV_RAW;
            end
         end
         rlcg_pkg::ST_DIV_RAW: begin
            if (div_status.done) begin
               state_in = rlcg_pkg::ST_CLAMP;
            end
         end
         rlcg_pkg::ST_CLAMP:    state_in = rlcg_pkg::ST_DONE;
         rlcg_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = rlcg_pkg::ST_IDLE;
            end
         end
         default:               state_in = rlcg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready         = 1'b0;
      lcg_ctrl.load_tick = 1'b0;
      lcg_ctrl.step      = 1'b0;
      div_ctrl.start     = 1'b0;
      div_dividend       = rlcg_pkg::RAW_MAX;
      div_divisor        = span_ff;
      case (state_ff)
         rlcg_pkg::ST_IDLE:     req_tready = 1'b1;
         rlcg_pkg::ST_SEED:     lcg_ctrl.load_tick = 1'b1;
         rlcg_pkg::ST_STEP: begin
            lcg_ctrl.step  = 1'b1;
            div_ctrl.start = 1'b1;
         end
         rlcg_pkg::ST_DIV_SPAN: begin
            div_ctrl.start = div_status.done;
            div_dividend   = raw;
            div_divisor    = div_quotient;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rlcg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         rlcg_pkg::ST_IDLE: begin
            if (req_xfer) begin
               lo_ff   <= req_tdata[31:0];
               hi_ff   <= req_tdata[63:32];
               tick_ff <= req_tdata[95:64];
            end
         end
         rlcg_pkg::ST_CHECK: begin
            span_ff   <= rlcg_pkg::DIV_W'(diff + 33'sd1);
            result_ff <= lo_ff;
            err_ff    <= in_order && too_wide;
         end
         rlcg_pkg::ST_DIV_RAW: begin
            value_ff <= {lo_ff[31], lo_ff} + {2'b00, div_quotient};
         end
         rlcg_pkg::ST_CLAMP: begin
            err_ff <= 1'b0;
            if (value_ff > $signed({hi_ff[31], hi_ff})) begin
               result_ff <= hi_ff;
            end else begin
               result_ff <= value_ff[31:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == rlcg_pkg::ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == rlcg_pkg::ST_DONE && out_free) begin
         rsp_data_ff <= result_ff;
         rsp_user_ff <= err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: sim/ranged_lcg_random_tb.sv
// ----------------------------------------------------------------------------
// ranged_lcg_random_tb
// Self-checking bench for the ranged LCG draw. Requests go in from a queue
// with random gaps, results come out under random back-pressure, and each
// result is compared with a local copy of the generator and range scaling.
// ----------------------------------------------------------------------------
module ranged_lcg_random_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] MULTIPLIER = 32'd1664525;
   localparam logic [31:0] INCREMENT  = 32'd1013904223;
   localparam longint      HALF_RANGE = 64'sd1073741824;
   localparam longint      DRAW_MAX   = 64'sd2147483647;
   localparam longint      SPAN_CAP   = 64'sd2147483648;
   localparam longint      WORD_SPAN  = 64'sd4294967296;
   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
   localparam int RANDOM_DRAWS = 600;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE       = 100;

   typedef struct {
      logic signed [31:0] low;
      logic signed [31:0] high;
      logic [31:0]        tick;
      logic               drain;
   } draw_req_type;

   typedef struct {
      logic signed [31:0] value;
      logic               span_error;
   } draw_res_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   draw_req_type pending_draws[$];
   draw_res_type expected_draws[$];
   logic [31:0] lcg_seed = '0;
   int  issued = 0;
   int  req_transfers = 0;
   int  rsp_transfers = 0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   int  idle_cycles = 0;
   int  error_count = 0;

   ranged_lcg_random i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   function automatic draw_res_type next_draw(draw_req_type req);
      draw_res_type       res;
      longint             lo, hi, span, raw, divisor, value;
      logic signed [31:0] half;
      lo = longint'(req.low);
      hi = longint'(req.high);
      res.value = req.low;
      res.span_error = 1'b0;
      if (hi > lo) begin
         span = hi - lo + 1;
         if (span >= SPAN_CAP) begin
            res.span_error = 1'b1;
         end else begin
            if (lcg_seed == 32'd0) lcg_seed = MULTIPLIER * req.tick + INCREMENT;
            lcg_seed = MULTIPLIER * lcg_seed + INCREMENT;
            half = $signed(lcg_seed) >>> 1;
            raw = longint'(half) + HALF_RANGE;
            divisor = DRAW_MAX / span;
            value = lo + raw / divisor;
            if (value > hi) value = hi;
            res.value = value[31:0];
         end
      end
      return res;
   endfunction

   function automatic draw_req_type random_draw();
      draw_req_type     req;
      int               kind;
      longint           span, lo, hi;
      longint unsigned  r;
      logic signed [31:0] a, b;
      kind = $urandom_range(0, 9);
      req.tick = $urandom;
      req.drain = 1'b0;
      case (kind)
         0, 1, 2, 3: span = $urandom_range(2, 64);
         4, 5:       span = $urandom_range(2, 32'h7FFF_FFFF);
         6:          span = SPAN_CAP - $urandom_range(1, 4);
         7: begin
            if ($urandom_range(0, 1)) span = SPAN_CAP + $urandom_range(0, 3);
            else span = SPAN_CAP + $urandom_range(0, 32'h7FFF_FFFF) + 1;
         end
         default: span = 0;
      endcase
      if (kind == 8) begin
         a = $urandom;
         b = $urandom;
         req.low  = (a >= b) ? a : b;
         req.high = (a >= b) ? b : a;
      end else if (kind == 9) begin
         req.low  = $urandom;
         req.high = $urandom;
      end else begin
         r = {$urandom, $urandom};
         case ($urandom_range(0, 7))
            0:       lo = longint'(INT_MIN);
            1:       lo = longint'(INT_MAX) - span + 1;
            default: lo = longint'(INT_MIN) + longint'(r % (WORD_SPAN - span + 1));
         endcase
         hi = lo + span - 1;
         req.low  = lo[31:0];
         req.high = hi[31:0];
      end
      return req;
   endfunction

   task automatic queue_draw(logic signed [31:0] low, logic signed [31:0] high,
                             logic [31:0] tick);
      draw_req_type req;
      req.low = low;
      req.high = high;
      req.tick = tick;
      req.drain = 1'b0;
      pending_draws.push_back(req);
   endtask

   // request side
   always @(negedge clock) begin
      draw_req_type req;
      logic         next_valid;
      if (!reset) begin
         if (!req_tvalid || req_transfers == issued) begin
            next_valid = 1'b0;
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_draws.size() != 0 &&
                         !(pending_draws[0].drain && expected_draws.size() != 0)) begin
               req = pending_draws.pop_front();
               next_valid = 1'b1;
               req_tdata <= {req.tick, req.high, req.low};
               issued++;
               req_gap = ((issued / 32) % 4 == 3) ? 0 : pick_gap();
            end
            req_tvalid <= next_valid;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if ((rsp_transfers / 32) % 4 == 1 || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_stall = pick_gap();
            rsp_tready <= (rsp_stall == 0);
            if (rsp_stall > 0) rsp_stall--;
         end
      end
   end

   // predict on request transfer, compare on result transfer
   always @(posedge clock) begin
      draw_req_type req;
      draw_res_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req.low  = req_tdata[31:0];
            req.high = req_tdata[63:32];
            req.tick = req_tdata[95:64];
            req.drain = 1'b0;
            expected_draws.push_back(next_draw(req));
            req_transfers++;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_transfers++;
            if (expected_draws.size() == 0) begin
               $display("%0t: unexpected result value %0d error %0b", $time,
                        $signed(rsp_tdata), rsp_tuser);
               error_count++;
            end else begin
               want = expected_draws.pop_front();
               if (rsp_tdata !== want.value) begin
                  $display("%0t: random_value expected %0d actual %0d", $time,
                           want.value, $signed(rsp_tdata));
                  error_count++;
               end
               if (rsp_tuser !== want.span_error) begin
                  $display("%0t: span_error expected %0b actual %0b", $time,
                           want.span_error, rsp_tuser);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      draw_req_type req;
      logic [31:0]  inv, pre_zero, zero_tick;
      inv = MULTIPLIER;
      repeat (5) inv = inv * (32'd2 - MULTIPLIER * inv);
      pre_zero = (32'd0 - INCREMENT) * inv;
      zero_tick = (pre_zero - INCREMENT) * inv;

      // seed from tick, step onto zero, then reseed
      queue_draw(32'sd0, 32'sd9, zero_tick);
      queue_draw(32'sd0, 32'sd9, 32'hFFFF_FFFF);
      queue_draw(32'sd5, 32'sd5, $urandom);
      queue_draw(32'sd7, -32'sd3, $urandom);
      queue_draw(INT_MAX, INT_MIN, $urandom);
      queue_draw(INT_MIN, INT_MAX, $urandom);
      queue_draw(-32'sd1, INT_MAX - 1, $urandom);
      queue_draw(INT_MIN, -32'sd1, $urandom);
      queue_draw(32'sd0, INT_MAX - 1, 32'd0);
      queue_draw(INT_MIN, -32'sd2, $urandom);
      queue_draw(INT_MIN + 1, INT_MAX, $urandom);
      queue_draw(INT_MAX - 1, INT_MAX, $urandom);
      queue_draw(INT_MIN, INT_MIN + 1, $urandom);
      queue_draw(32'sd0, 32'sd1, $urandom);
      queue_draw(32'sd0, 32'sd3, $urandom);
      for (int i = 0; i < 6; i++) queue_draw(-32'sd100, 32'sh4000_0000 - 100, $urandom);
      queue_draw(INT_MIN, INT_MIN + 32'sh4000_0000, $urandom);
      queue_draw(INT_MAX - 32'sh4000_0000, INT_MAX, $urandom);

      for (int i = 0; i < RANDOM_DRAWS; i++) begin
         req = random_draw();
         req.drain = (i % 150 == 0);
         pending_draws.push_back(req);
      end

      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_draws.size() != 0 || req_tvalid || expected_draws.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (expected_draws.size() != 0) begin
         $display("%0t: %0d results expected, none arrived", $time, expected_draws.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
